// File: rtl/core/hopf_oscillator_derivative_assert.svh
// Assertion macros shared by the Hopf oscillator derivative RTL.
`ifndef HOPF_OSCILLATOR_DERIVATIVE_ASSERT_SVH
`define HOPF_OSCILLATOR_DERIVATIVE_ASSERT_SVH
`ifndef SYNTH
`define HOD_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hopf oscillator derivative: same-cycle check failed");
`define HOD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hopf oscillator derivative: next-cycle check failed");
`else
`define HOD_ASSERT(label, clk, rst_n, ante, cons)
`define HOD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/hod_pkg.sv
// Shared constants and register codes of the Hopf oscillator derivative.
`default_nettype none
package hod_pkg;
  localparam int unsigned HOD_WORD_WIDTH = 32;
  localparam int unsigned HOD_FRAC_BITS  = 16;
  localparam int unsigned HOD_STEPS      = 4;
  localparam int unsigned HOD_CFG_IDX_W  = 3;
  localparam int unsigned HOD_BANK_W     = 3;
  localparam int unsigned BANK_ALPHA     = 0;
  localparam int unsigned BANK_OMEGA     = 1;
  localparam int unsigned BANK_GAMMA     = 2;

  typedef enum logic [HOD_CFG_IDX_W-1:0] {
    CFG_ALPHA = 3'd0,
    CFG_OMEGA = 3'd1,
    CFG_GAMMA = 3'd2,
    CFG_SHIFT = 3'd3,
    CFG_BANK  = 3'd4
  } hod_cfg_idx_t;
endpackage
`default_nettype wire

// File: rtl/core/hopf_oscillator_derivative.sv
// Top level: Hopf oscillator normal-form derivative, fully pipelined.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_ready  state_u, state_v, item_alpha, item_omega, item_gamma
//  out_     output     out_valid/out_ready  rate_u, rate_v, domain_error, saturated
//  cfg_     input      cfg_we (no wait)     cfg_index, cfg_data
//
// One item enters per cycle and one result leaves per cycle unless the output
// stalls. The pipe is the ratio divider, then the square-root pipeline, then
// the eight multiply and round/saturate stages.
// Synchronous active-low reset clears the valid bits and loads the registers
// with alpha = omega = gamma = 1.0, shift 0, bank select 0.
// A stall on the output freezes every stage at once; nothing is dropped or repeated.
`default_nettype none
`include "hopf_oscillator_derivative_assert.svh"
module hopf_oscillator_derivative #(
  parameter int unsigned WORD_WIDTH = hod_pkg::HOD_WORD_WIDTH,
  parameter int unsigned FRAC_BITS  = hod_pkg::HOD_FRAC_BITS,
  parameter int unsigned STEPS      = hod_pkg::HOD_STEPS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [WORD_WIDTH-1:0]        in_state_u,
  input  logic signed [WORD_WIDTH-1:0]        in_state_v,
  input  logic signed [WORD_WIDTH-1:0]        in_item_alpha,
  input  logic signed [WORD_WIDTH-1:0]        in_item_omega,
  input  logic signed [WORD_WIDTH-1:0]        in_item_gamma,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [WORD_WIDTH-1:0]        out_rate_u,
  output logic signed [WORD_WIDTH-1:0]        out_rate_v,
  output logic                                out_domain_error,
  output logic                                out_saturated,
  input  logic                                cfg_we,
  input  logic [hod_pkg::HOD_CFG_IDX_W-1:0]   cfg_index,
  input  logic [WORD_WIDTH-1:0]               cfg_data
);
  import hod_pkg::*;

  localparam int unsigned W  = WORD_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned NT = 8;
  localparam logic [PW-1:0]       HALF   = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [W-1:0] FX_ONE = W'(1) << FRAC_BITS;
  localparam logic signed [W-1:0] FX_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] FX_MIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic                err;
    logic                sat;
    logic signed [W-1:0] u;
    logic signed [W-1:0] v;
    logic signed [W-1:0] alpha;
    logic signed [W-1:0] omega;
    logic signed [W-1:0] gamma;
  } pl_t;

  typedef struct packed {
    logic          neg;
    logic [PW-1:0] p;
  } prod_t;

  typedef struct packed {
    logic                ovf;
    logic signed [W-1:0] val;
  } fx_t;

  localparam int unsigned PL_W = $bits(pl_t);

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
    return a[W-1] ? W'(-a) : W'(a);
  endfunction

  // exact product of magnitudes, sign kept aside
  function automatic prod_t fx_prod(input logic signed [W-1:0] a, input logic signed [W-1:0] b);
    prod_t r;
    r.neg = a[W-1] ^ b[W-1];
    r.p   = {{W{1'b0}}, mag(a)} * {{W{1'b0}}, mag(b)};
    return r;
  endfunction

  // round half away from zero, drop fraction bits, saturate
  function automatic fx_t fx_rnd(input prod_t x);
    fx_t           r;
    logic [PW-1:0] q;
    logic [PW-1:0] lim;
    q     = (x.p + HALF) >> FRAC_BITS;
    lim   = PW'({x.neg, {(W-1){~x.neg}}});
    r.ovf = q > lim;
    if (r.ovf) begin
      r.val = x.neg ? FX_MIN : FX_MAX;
    end else begin
      r.val = x.neg ? -$signed(q[W-1:0]) : $signed(q[W-1:0]);
    end
    return r;
  endfunction

  function automatic fx_t fx_addsub(input logic signed [W-1:0] a, input logic signed [W-1:0] b,
                                    input logic sub);
    fx_t        r;
    logic [W:0] s;
    s     = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
    r.ovf = s[W] != s[W-1];
    r.val = r.ovf ? (s[W] ? FX_MIN : FX_MAX) : $signed(s[W-1:0]);
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic signed [W-1:0]     galpha_r;
  logic signed [W-1:0]     gomega_r;
  logic signed [W-1:0]     ggamma_r;
  logic signed [W-1:0]     shift_r;
  logic [HOD_BANK_W-1:0]   bank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      galpha_r <= FX_ONE;
      gomega_r <= FX_ONE;
      ggamma_r <= FX_ONE;
      shift_r  <= '0;
      bank_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHA: galpha_r <= cfg_data;
        CFG_OMEGA: gomega_r <= cfg_data;
        CFG_GAMMA: ggamma_r <= cfg_data;
        CFG_SHIFT: shift_r  <= cfg_data;
        CFG_BANK:  bank_r   <= cfg_data[HOD_BANK_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // One enable for the whole pipe: advance whenever the output register is
  // empty or being drained.
  logic          en;
  logic [NT-1:0] vld_r;

  assign en        = !vld_r[NT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NT-1];

  // ---------------------------------------------------------------- entry
  // Pick per-item or shared parameters and flag the domain error up front.
  pl_t pl_in;

  always_comb begin
    pl_in.u     = in_state_u;
    pl_in.v     = in_state_v;
    pl_in.alpha = bank_r[BANK_ALPHA] ? in_item_alpha : galpha_r;
    pl_in.omega = bank_r[BANK_OMEGA] ? in_item_omega : gomega_r;
    pl_in.gamma = bank_r[BANK_GAMMA] ? in_item_gamma : ggamma_r;
    pl_in.err   = (pl_in.gamma == '0) ||
                  ((pl_in.alpha != '0) && (pl_in.alpha[W-1] != pl_in.gamma[W-1]));
    pl_in.sat   = 1'b0;
  end

  // ---------------------------------------------------------------- radius
  logic            dv_vld;
  logic [W-1:0]    dv_ratio;
  logic            dv_sat;
  logic [PL_W-1:0] dv_side;
  logic            sq_vld;
  logic [W-1:0]    sq_root;
  logic            sq_sat;
  logic [PL_W:0]   sq_side;

  hod_div #(
    .WORD_WIDTH (W),
    .FRAC_BITS  (FRAC_BITS),
    .STEPS      (STEPS),
    .SIDE_W     (PL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .num_mag  (mag(pl_in.alpha)),
    .den_mag  (mag(pl_in.gamma)),
    .in_side  (pl_in),
    .out_vld  (dv_vld),
    .quo      (dv_ratio),
    .quo_sat  (dv_sat),
    .out_side (dv_side)
  );

  hod_sqrt #(
    .WORD_WIDTH (W),
    .FRAC_BITS  (FRAC_BITS),
    .STEPS      (STEPS),
    .SIDE_W     (PL_W + 1)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (dv_vld),
    .ratio    (dv_ratio),
    .in_side  ({dv_sat, dv_side}),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .root_sat (sq_sat),
    .out_side (sq_side)
  );

  // ---------------------------------------------------------------- datapath
  pl_t   pl1_r, pl2_r, pl3_r, pl4_r, pl5_r, pl6_r, pl7_r;
  pl_t   pl1_n, pl2_n, pl4_n, pl6_n;
  prod_t p1_r;
  prod_t puu_r, pvv_r;
  logic signed [W-1:0] r2_r;
  logic signed [W-1:0] r2_n;
  prod_t pg_r, pau_r, pov_r, pav_r, pou_r;
  logic signed [W-1:0] g_r, du1_r, dv1_r;
  logic signed [W-1:0] g_n, du1_n, dv1_n;
  prod_t pgu_r, pgv_r;
  logic signed [W-1:0] du7_r, dv7_r;
  logic signed [W-1:0] rate_u_r, rate_v_r, rate_u_n, rate_v_n;
  logic                err_r, sat_r, sat_n;

  // stage 1: fold in divider and root saturation
  always_comb begin
    pl1_n     = pl_t'(sq_side[PL_W-1:0]);
    pl1_n.sat = sq_side[PL_W] | sq_sat;
  end

  // stage 2: move u by shift times radius
  always_comb begin
    fx_t a;
    fx_t b;
    a         = fx_rnd(p1_r);
    b         = fx_addsub(pl1_r.u, a.val, 1'b0);
    pl2_n     = pl1_r;
    pl2_n.u   = b.val;
    pl2_n.sat = pl1_r.sat | a.ovf | b.ovf;
  end

  // stage 4: squared radius of the moved state
  always_comb begin
    fx_t a;
    fx_t b;
    fx_t c;
    a         = fx_rnd(puu_r);
    b         = fx_rnd(pvv_r);
    c         = fx_addsub(a.val, b.val, 1'b0);
    r2_n      = c.val;
    pl4_n     = pl3_r;
    pl4_n.sat = pl3_r.sat | a.ovf | b.ovf | c.ovf;
  end

  // stage 6: damping factor and the linear parts
  always_comb begin
    fx_t g;
    fx_t au;
    fx_t ov;
    fx_t av;
    fx_t ou;
    fx_t du;
    fx_t dv;
    g         = fx_rnd(pg_r);
    au        = fx_rnd(pau_r);
    ov        = fx_rnd(pov_r);
    av        = fx_rnd(pav_r);
    ou        = fx_rnd(pou_r);
    du        = fx_addsub(au.val, ov.val, 1'b1);
    dv        = fx_addsub(av.val, ou.val, 1'b0);
    g_n       = g.val;
    du1_n     = du.val;
    dv1_n     = dv.val;
    pl6_n     = pl5_r;
    pl6_n.sat = pl5_r.sat | g.ovf | au.ovf | ov.ovf | av.ovf | ou.ovf | du.ovf | dv.ovf;
  end

  // stage 8: subtract the cubic term; a domain error forces zeros
  always_comb begin
    fx_t x;
    fx_t y;
    fx_t du;
    fx_t dv;
    x  = fx_rnd(pgu_r);
    y  = fx_rnd(pgv_r);
    du = fx_addsub(du7_r, x.val, 1'b1);
    dv = fx_addsub(dv7_r, y.val, 1'b1);
    if (pl7_r.err) begin
      rate_u_n = '0;
      rate_v_n = '0;
      sat_n    = 1'b0;
    end else begin
      rate_u_n = du.val;
      rate_v_n = dv.val;
      sat_n    = pl7_r.sat | x.ovf | y.ovf | du.ovf | dv.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NT-2:0], sq_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl1_r    <= pl1_n;
      p1_r     <= fx_prod(shift_r, $signed(sq_root));
      pl2_r    <= pl2_n;
      pl3_r    <= pl2_r;
      puu_r    <= fx_prod(pl2_r.u, pl2_r.u);
      pvv_r    <= fx_prod(pl2_r.v, pl2_r.v);
      pl4_r    <= pl4_n;
      r2_r     <= r2_n;
      pl5_r    <= pl4_r;
      pg_r     <= fx_prod(r2_r, pl4_r.gamma);
      pau_r    <= fx_prod(pl4_r.alpha, pl4_r.u);
      pov_r    <= fx_prod(pl4_r.omega, pl4_r.v);
      pav_r    <= fx_prod(pl4_r.alpha, pl4_r.v);
      pou_r    <= fx_prod(pl4_r.omega, pl4_r.u);
      pl6_r    <= pl6_n;
      g_r      <= g_n;
      du1_r    <= du1_n;
      dv1_r    <= dv1_n;
      pl7_r    <= pl6_r;
      pgu_r    <= fx_prod(g_r, pl6_r.u);
      pgv_r    <= fx_prod(g_r, pl6_r.v);
      du7_r    <= du1_r;
      dv7_r    <= dv1_r;
      rate_u_r <= rate_u_n;
      rate_v_r <= rate_v_n;
      err_r    <= pl7_r.err;
      sat_r    <= sat_n;
    end
  end

  assign out_rate_u       = rate_u_r;
  assign out_rate_v       = rate_v_r;
  assign out_domain_error = err_r;
  assign out_saturated    = sat_r;

  // ---------------------------------------------------------------- checks
  `HOD_ASSERT(a_err_zeroes, clk, rst_n, out_valid && out_domain_error, out_rate_u == '0 && out_rate_v == '0 && !out_saturated)
  `HOD_ASSERT_NEXT(a_stall_freezes, clk, rst_n, !en, $stable(vld_r))
  `HOD_ASSERT_NEXT(a_last_stage_lands, clk, rst_n, vld_r[NT-2] && en, out_valid)
endmodule
`default_nettype wire

// File: rtl/core/hod_div.sv
// Pipelined restoring divider giving the saturated fixed-point ratio of two magnitudes.
`default_nettype none
module hod_div #(
  parameter int unsigned WORD_WIDTH = hod_pkg::HOD_WORD_WIDTH,
  parameter int unsigned FRAC_BITS  = hod_pkg::HOD_FRAC_BITS,
  parameter int unsigned STEPS      = hod_pkg::HOD_STEPS,
  parameter int unsigned SIDE_W     = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [WORD_WIDTH-1:0] num_mag,
  input  logic [WORD_WIDTH-1:0] den_mag,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_vld,
  output logic [WORD_WIDTH-1:0] quo,
  output logic                  quo_sat,
  output logic [SIDE_W-1:0]     out_side
);
  import hod_pkg::*;

  localparam int unsigned QB = WORD_WIDTH + FRAC_BITS;
  localparam int unsigned NS = (QB + STEPS - 1) / STEPS;
  localparam int unsigned RW = WORD_WIDTH + 1;

  logic [NS-1:0]         vld_r;
  logic [RW-1:0]         rem_r  [NS];
  logic [QB-1:0]         quo_r  [NS];
  logic [QB-1:0]         dvd_r  [NS];
  logic [WORD_WIDTH-1:0] den_r  [NS];
  logic [SIDE_W-1:0]     side_r [NS];
  logic [RW-1:0]         rem_n  [NS];
  logic [QB-1:0]         quo_n  [NS];
  logic [QB-1:0]         dvd_n  [NS];
  logic [WORD_WIDTH-1:0] den_n  [NS];
  logic [SIDE_W-1:0]     side_n [NS];
  logic [NS-1:0]         vld_n;

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [RW-1:0]         rem_i;
    logic [QB-1:0]         quo_i;
    logic [QB-1:0]         dvd_i;
    logic [WORD_WIDTH-1:0] den_i;
    logic [SIDE_W-1:0]     side_i;
    logic                  vld_i;
    logic [RW-1:0]         rem_c;
    logic [QB-1:0]         quo_c;
    logic [QB-1:0]         dvd_c;

    if (s == 0) begin : g_first
      assign rem_i  = '0;
      assign quo_i  = '0;
      assign dvd_i  = {num_mag, {FRAC_BITS{1'b0}}};
      assign den_i  = den_mag;
      assign side_i = in_side;
      assign vld_i  = in_vld;
    end else begin : g_next
      assign rem_i  = rem_r[s-1];
      assign quo_i  = quo_r[s-1];
      assign dvd_i  = dvd_r[s-1];
      assign den_i  = den_r[s-1];
      assign side_i = side_r[s-1];
      assign vld_i  = vld_r[s-1];
    end

    // one quotient bit per step, shift in the next dividend bit
    always_comb begin
      rem_c = rem_i;
      quo_c = quo_i;
      dvd_c = dvd_i;
      for (int k = 0; k < STEPS; k++) begin
        if (s * STEPS + k < QB) begin
          rem_c = {rem_c[RW-2:0], dvd_c[QB-1]};
          dvd_c = {dvd_c[QB-2:0], 1'b0};
          if (rem_c >= {1'b0, den_i}) begin
            rem_c = rem_c - {1'b0, den_i};
            quo_c = {quo_c[QB-2:0], 1'b1};
          end else begin
            quo_c = {quo_c[QB-2:0], 1'b0};
          end
        end
      end
    end

    assign rem_n[s]  = rem_c;
    assign quo_n[s]  = quo_c;
    assign dvd_n[s]  = dvd_c;
    assign den_n[s]  = den_i;
    assign side_n[s] = side_i;
    assign vld_n[s]  = vld_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_n;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        rem_r[s]  <= rem_n[s];
        quo_r[s]  <= quo_n[s];
        dvd_r[s]  <= dvd_n[s];
        den_r[s]  <= den_n[s];
        side_r[s] <= side_n[s];
      end
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign out_side = side_r[NS-1];
  assign quo_sat  = |quo_r[NS-1][QB-1:WORD_WIDTH-1];
  assign quo      = quo_sat ? {1'b0, {(WORD_WIDTH-1){1'b1}}} : quo_r[NS-1][WORD_WIDTH-1:0];
endmodule
`default_nettype wire

// File: rtl/core/hod_sqrt.sv
// Pipelined digit-by-digit square root of a fixed-point ratio, saturated to the word.
`default_nettype none
module hod_sqrt #(
  parameter int unsigned WORD_WIDTH = hod_pkg::HOD_WORD_WIDTH,
  parameter int unsigned FRAC_BITS  = hod_pkg::HOD_FRAC_BITS,
  parameter int unsigned STEPS      = hod_pkg::HOD_STEPS,
  parameter int unsigned SIDE_W     = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [WORD_WIDTH-1:0] ratio,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_vld,
  output logic [WORD_WIDTH-1:0] root,
  output logic                  root_sat,
  output logic [SIDE_W-1:0]     out_side
);
  import hod_pkg::*;

  localparam int unsigned SB = (WORD_WIDTH + FRAC_BITS + 1) / 2;
  localparam int unsigned RB = 2 * SB;
  localparam int unsigned RW = SB + 2;
  localparam int unsigned NS = (SB + STEPS - 1) / STEPS;

  logic [NS-1:0]     vld_r;
  logic [RW-1:0]     rem_r  [NS];
  logic [SB-1:0]     y_r    [NS];
  logic [RB-1:0]     rad_r  [NS];
  logic [SIDE_W-1:0] side_r [NS];
  logic [RW-1:0]     rem_n  [NS];
  logic [SB-1:0]     y_n    [NS];
  logic [RB-1:0]     rad_n  [NS];
  logic [SIDE_W-1:0] side_n [NS];
  logic [NS-1:0]     vld_n;
  logic [RB-1:0]     rad0;

  assign rad0 = {{(RB-WORD_WIDTH){1'b0}}, ratio} << FRAC_BITS;

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [RW-1:0]     rem_i;
    logic [SB-1:0]     y_i;
    logic [RB-1:0]     rad_i;
    logic [SIDE_W-1:0] side_i;
    logic              vld_i;
    logic [RW-1:0]     rem_c;
    logic [SB-1:0]     y_c;
    logic [RB-1:0]     rad_c;
    logic [RW-1:0]     trial;

    if (s == 0) begin : g_first
      assign rem_i  = '0;
      assign y_i    = '0;
      assign rad_i  = rad0;
      assign side_i = in_side;
      assign vld_i  = in_vld;
    end else begin : g_next
      assign rem_i  = rem_r[s-1];
      assign y_i    = y_r[s-1];
      assign rad_i  = rad_r[s-1];
      assign side_i = side_r[s-1];
      assign vld_i  = vld_r[s-1];
    end

    // one root bit per step from the next pair of radicand bits
    always_comb begin
      rem_c = rem_i;
      y_c   = y_i;
      rad_c = rad_i;
      trial = '0;
      for (int k = 0; k < STEPS; k++) begin
        if (s * STEPS + k < SB) begin
          rem_c = {rem_c[RW-3:0], rad_c[RB-1:RB-2]};
          rad_c = {rad_c[RB-3:0], 2'b00};
          trial = {y_c, 2'b01};
          if (rem_c >= trial) begin
            rem_c = rem_c - trial;
            y_c   = {y_c[SB-2:0], 1'b1};
          end else begin
            y_c   = {y_c[SB-2:0], 1'b0};
          end
        end
      end
    end

    assign rem_n[s]  = rem_c;
    assign y_n[s]    = y_c;
    assign rad_n[s]  = rad_c;
    assign side_n[s] = side_i;
    assign vld_n[s]  = vld_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_n;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        rem_r[s]  <= rem_n[s];
        y_r[s]    <= y_n[s];
        rad_r[s]  <= rad_n[s];
        side_r[s] <= side_n[s];
      end
    end
  end

  logic [SB+WORD_WIDTH-1:0] y_ext;
  logic [SB+WORD_WIDTH-1:0] max_ext;

  assign y_ext    = {{WORD_WIDTH{1'b0}}, y_r[NS-1]};
  assign max_ext  = {{(SB+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};
  assign root_sat = y_ext > max_ext;
  assign root     = root_sat ? max_ext[WORD_WIDTH-1:0] : y_ext[WORD_WIDTH-1:0];
  assign out_vld  = vld_r[NS-1];
  assign out_side = side_r[NS-1];
endmodule
`default_nettype wire
